[hdl/ipv4rx_pkg.sv]
package ipv4rx_pkg;

	localparam int unsigned COUNT_W = 17;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_W-1:0] ETH_HDR_LEN = 17'd14;
	localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 17'd34;
	localparam logic [COUNT_W-1:0] POS_TYPE_HI = 17'd12;
	localparam logic [COUNT_W-1:0] POS_TYPE_LO = 17'd13;
	localparam logic [COUNT_W-1:0] POS_VER_IHL = 17'd14;
	localparam logic [COUNT_W-1:0] POS_TLEN_HI = 17'd16;
	localparam logic [COUNT_W-1:0] POS_TLEN_LO = 17'd17;
	localparam logic [COUNT_W-1:0] POS_FRAG_HI = 17'd20;
	localparam logic [COUNT_W-1:0] POS_FRAG_LO = 17'd21;
	localparam logic [COUNT_W-1:0] POS_PROTO = 17'd23;
	localparam logic [COUNT_W-1:0] POS_SRC_FIRST = 17'd26;
	localparam logic [COUNT_W-1:0] POS_SRC_LAST = 17'd29;
	localparam logic [COUNT_W-1:0] POS_DST_FIRST = 17'd30;
	localparam logic [COUNT_W-1:0] POS_DST_LAST = 17'd33;
	localparam logic [7:0] ETYPE_HI = 8'h08;
	localparam logic [7:0] ETYPE_LO = 8'h00;
	localparam logic [3:0] IP_VERSION = 4'd4;
	localparam logic [5:0] MIN_IHL = 6'd20;
	localparam logic [15:0] SUM_GOOD = 16'hFFFF;

	localparam int QUEUE_DEPTH_DEFAULT = 2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_NOT_IPV4  = 3'd2,
		ST_VERSION   = 3'd3,
		ST_LENGTH    = 3'd4,
		ST_CHECKSUM  = 3'd5,
		ST_FRAGMENT  = 3'd6,
		ST_DEST      = 3'd7
	} status_t;

	// Summary of one frame, handed from the byte parser to the verdict stage.
	typedef struct packed {
		logic [COUNT_W-1:0] frame_len;
		logic               ethertype_ok;
		logic [3:0]         version;
		logic [3:0]         header_words;
		logic [15:0]        total_length;
		logic [15:0]        checksum;
		logic               fragment_set;
		logic [7:0]         protocol;
		logic [31:0]        source;
		logic [31:0]        destination;
	} frame_info_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  protocol;
		logic [31:0] source;
		logic [6:0]  offset;
		logic [15:0] length;
	} result_t;

endpackage

[hdl/ipv4rx_parser.sv]
module ipv4rx_parser
	import ipv4rx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        info_push,
	output frame_info_t info
);

	logic [COUNT_W-1:0] byte_count_q;
	logic               ethertype_ok_q, ethertype_ok_d;
	logic [3:0]         version_q, version_d;
	logic [3:0]         header_words_q, header_words_d;
	logic [15:0]        total_length_q, total_length_d;
	logic [15:0]        checksum_q, checksum_d;
	logic [7:0]         pending_q, pending_d;
	logic [13:0]        fragment_q, fragment_d;
	logic [7:0]         protocol_q, protocol_d;
	logic [31:0]        source_q, source_d;
	logic [31:0]        destination_q, destination_d;
	logic [COUNT_W-1:0] pos;
	logic [COUNT_W-1:0] header_end;
	logic [16:0]        sum_wide;

	assign pos = byte_count_q;

	always_comb begin
		ethertype_ok_d = ethertype_ok_q;
		version_d = version_q;
		header_words_d = header_words_q;
		total_length_d = total_length_q;
		checksum_d = checksum_q;
		pending_d = pending_q;
		fragment_d = fragment_q;
		protocol_d = protocol_q;
		source_d = source_q;
		destination_d = destination_q;

		if (pos == POS_TYPE_HI) ethertype_ok_d = (data_byte == ETYPE_HI);
		if (pos == POS_TYPE_LO) ethertype_ok_d = ethertype_ok_q && (data_byte == ETYPE_LO);
		if (pos == POS_VER_IHL) begin
			version_d = data_byte[7:4];
			header_words_d = data_byte[3:0];
		end
		if (pos == POS_TLEN_HI) total_length_d[15:8] = data_byte;
		if (pos == POS_TLEN_LO) total_length_d[7:0] = data_byte;
		if (pos == POS_FRAG_HI) fragment_d[13:8] = data_byte[5:0];
		if (pos == POS_FRAG_LO) fragment_d[7:0] = data_byte;
		if (pos == POS_PROTO) protocol_d = data_byte;
		if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) source_d = {source_q[23:0], data_byte};
		if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
			destination_d = {destination_q[23:0], data_byte};
		end

		// The header length seen by the sum is the one in effect after this byte.
		header_end = ETH_HDR_LEN + COUNT_W'({header_words_d, 2'b00});
		sum_wide = {1'b0, checksum_q} + {1'b0, pending_q, data_byte};
		if (pos >= ETH_HDR_LEN && pos < header_end) begin
			if (!pos[0]) begin
				pending_d = data_byte;
			end else begin
				checksum_d = sum_wide[15:0] + {15'd0, sum_wide[16]};
			end
		end

		info.frame_len = (pos < COUNT_MAX) ? pos + 1'b1 : COUNT_MAX;
		info.ethertype_ok = ethertype_ok_d;
		info.version = version_d;
		info.header_words = header_words_d;
		info.total_length = total_length_d;
		info.checksum = checksum_d;
		info.fragment_set = (fragment_d != 14'd0);
		info.protocol = protocol_d;
		info.source = source_d;
		info.destination = destination_d;
	end

	assign info_push = byte_valid && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			ethertype_ok_q <= 1'b0;
			version_q <= '0;
			header_words_q <= '0;
			total_length_q <= '0;
			checksum_q <= '0;
			pending_q <= '0;
			fragment_q <= '0;
			protocol_q <= '0;
			source_q <= '0;
			destination_q <= '0;
		end else if (byte_valid) begin
			if (last_byte) begin
				byte_count_q <= '0;
				ethertype_ok_q <= 1'b0;
				version_q <= '0;
				header_words_q <= '0;
				total_length_q <= '0;
				checksum_q <= '0;
				pending_q <= '0;
				fragment_q <= '0;
				protocol_q <= '0;
				source_q <= '0;
				destination_q <= '0;
			end else begin
				if (byte_count_q < COUNT_MAX) byte_count_q <= byte_count_q + 1'b1;
				ethertype_ok_q <= ethertype_ok_d;
				version_q <= version_d;
				header_words_q <= header_words_d;
				total_length_q <= total_length_d;
				checksum_q <= checksum_d;
				pending_q <= pending_d;
				fragment_q <= fragment_d;
				protocol_q <= protocol_d;
				source_q <= source_d;
				destination_q <= destination_d;
			end
		end
	end

endmodule

[hdl/ipv4rx_queue.sv]
module ipv4rx_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

[hdl/ipv4rx_verdict.sv]
module ipv4rx_verdict
	import ipv4rx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        info_valid,
	input  frame_info_t info,
	output logic        info_take,
	input  logic [31:0] local_address,
	output logic        result_valid,
	input  logic        result_pop,
	output result_t     result
);

	logic        out_valid_q;
	result_t     result_q;
	result_t     result_d;
	logic [5:0]  ihl;
	logic [COUNT_W-1:0] ip_end;

	assign ihl = {info.header_words, 2'b00};
	assign ip_end = ETH_HDR_LEN + COUNT_W'(info.total_length);

	always_comb begin
		result_d = '0;
		priority if (info.frame_len < MIN_FRAME_LEN) result_d.status = ST_SHORT;
		else if (!info.ethertype_ok) result_d.status = ST_NOT_IPV4;
		else if (info.version != IP_VERSION) result_d.status = ST_VERSION;
		else if (ihl < MIN_IHL || info.total_length < 16'(ihl) || ip_end > info.frame_len)
			result_d.status = ST_LENGTH;
		else if (info.checksum != SUM_GOOD) result_d.status = ST_CHECKSUM;
		else if (info.fragment_set) result_d.status = ST_FRAGMENT;
		else if (info.destination != local_address) result_d.status = ST_DEST;
		else result_d.status = ST_OK;

		if (result_d.status == ST_OK) begin
			result_d.protocol = info.protocol;
			result_d.source = info.source;
			result_d.offset = 7'(ETH_HDR_LEN) + 7'(ihl);
			result_d.length = info.total_length - 16'(ihl);
		end
	end

	// The output register refills in the same cycle its result is transferred.
	assign info_take = info_valid && (!out_valid_q || result_pop);
	assign result_valid = out_valid_q;
	assign result = result_q;

	always_ff @(posedge clk) begin
		if (info_take) result_q <= result_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (info_take) begin
			out_valid_q <= 1'b1;
		end else if (result_pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[hdl/ipv4_receive_header_checker.sv]
// IPv4 receive header checker for Ethernet frames.
// Input channel: one frame byte per transfer on data_byte, with last_byte set on the
// final byte. A byte is taken at a clock edge where push is high and full is low.
// Result channel: one verdict per frame. While empty is low, status and the payload
// fields show the oldest verdict; it is taken at an edge where pop is high.
// status 0 accepts the frame; any other code names the first failed check, and the
// protocol, address, offset and length fields then read zero.
// local_address is written by local_address_we and takes effect at the next edge;
// write it only while no frame is in flight.
// Throughput: one byte every cycle while full is low, set by the byte parser, which does
// one add and some field capture per byte. After the edge that takes the last byte, the
// verdict passes through the frame queue, then the verdict output register.
// Reset clears the byte count, the frame queue and the output register; no frame
// is in progress afterwards and local_address reads zero.
// When the receiver stalls, verdicts collect in the frame queue (QUEUE_DEPTH deep)
// behind the output register; once the queue is full, full rises and bytes wait.
module ipv4_receive_header_checker
	import ipv4rx_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [7:0]  protocol,
	output logic [31:0] source_address,
	output logic [6:0]  payload_offset,
	output logic [15:0] payload_length,
	input  logic        local_address_we,
	input  logic [31:0] local_address
);

	logic        local_address_q;
	logic [31:0] local_addr_q;
	logic        byte_valid;
	logic        info_push;
	frame_info_t info_in, info_out;
	logic        q_full, q_empty, info_take;
	logic        result_valid;
	result_t     result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
			local_address_q <= 1'b0;
		end else if (local_address_we) begin
			local_addr_q <= local_address;
			local_address_q <= 1'b1;
		end
	end

	// Bytes stall only while the frame queue has no room for a verdict.
	assign full = q_full;
	assign byte_valid = push && !q_full;

	ipv4rx_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.info_push  (info_push),
		.info       (info_in)
	);

	ipv4rx_queue #(
		.WIDTH ($bits(frame_info_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (info_push),
		.push_data (info_in),
		.full      (q_full),
		.pop       (info_take),
		.pop_data  (info_out),
		.empty     (q_empty)
	);

	ipv4rx_verdict u_verdict (
		.clk           (clk),
		.arst_n        (arst_n),
		.info_valid    (!q_empty),
		.info          (info_out),
		.info_take     (info_take),
		.local_address (local_addr_q),
		.result_valid  (result_valid),
		.result_pop    (pop),
		.result        (result)
	);

	assign empty = !result_valid;
	assign status = result.status;
	assign protocol = result.protocol;
	assign source_address = result.source;
	assign payload_offset = result.offset;
	assign payload_length = result.length;

	a_reject_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |->
		(protocol == 8'd0 && source_address == 32'd0 && payload_offset == 7'd0
			&& payload_length == 16'd0))
		else $error("rejected frame carries nonzero payload fields");

	a_accept_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_OK) |-> (payload_offset >= 7'd34 && payload_offset <= 7'd74))
		else $error("accepted frame has payload offset out of range");

	a_drain_to_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && q_empty) |=> empty)
		else $error("result still shown after last verdict was transferred");

	a_verdict_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && last_byte) |=> !q_empty)
		else $error("frame queue empty after a last byte was taken");

	a_config_seen: assert property (@(posedge clk) disable iff (!arst_n)
		local_address_we |=> (local_address_q && local_addr_q == $past(local_address)))
		else $error("local address write lost");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

import ipv4rx_pkg::*;

typedef enum int {
	FAULT_NONE,
	FAULT_SHORT,
	FAULT_ETHERTYPE,
	FAULT_VERSION,
	FAULT_IHL,
	FAULT_TLEN_SMALL,
	FAULT_TLEN_LONG,
	FAULT_CHECKSUM,
	FAULT_FRAGMENT,
	FAULT_DEST,
	FAULT_NOISE,
	FAULT_ZEROS
} frame_fault_t;

// Tracks the parser state byte by byte and holds the verdicts still owed by the block.
class header_verdict_predictor;
	logic [31:0]        station_address;
	logic [COUNT_W-1:0] byte_count;
	logic               ethertype_ok;
	logic [3:0]         version_field;
	logic [3:0]         header_words;
	logic [15:0]        total_length;
	logic [15:0]        checksum_sum;
	logic [7:0]         pending_high;
	logic [13:0]        fragment_field;
	logic [7:0]         protocol_reg;
	logic [31:0]        source_reg;
	logic [31:0]        dest_reg;

	result_t     expected_verdicts[$];
	int unsigned mismatches;
	int unsigned verdicts_checked;
	int unsigned status_seen[8];

	function new();
		station_address = '0;
		mismatches = 0;
		verdicts_checked = 0;
		foreach (status_seen[k]) status_seen[k] = 0;
		clear_frame();
	endfunction

	function void clear_frame();
		byte_count = '0;
		ethertype_ok = 1'b0;
		version_field = '0;
		header_words = '0;
		total_length = '0;
		checksum_sum = '0;
		pending_high = '0;
		fragment_field = '0;
		protocol_reg = '0;
		source_reg = '0;
		dest_reg = '0;
	endfunction

	function int unsigned outstanding();
		return expected_verdicts.size();
	endfunction

	function void note_byte(logic [7:0] value, logic is_last);
		logic [COUNT_W-1:0] pos;
		logic [COUNT_W-1:0] flen;
		logic [16:0]        acc;
		logic [5:0]         ihl_bytes;
		status_t            st;
		result_t            verdict;
		pos = byte_count;
		if (pos == POS_TYPE_HI) ethertype_ok = (value == ETYPE_HI);
		if (pos == POS_TYPE_LO) ethertype_ok = ethertype_ok && (value == ETYPE_LO);
		if (pos == POS_VER_IHL) begin
			version_field = value[7:4];
			header_words = value[3:0];
		end
		if (pos == POS_TLEN_HI) total_length[15:8] = value;
		if (pos == POS_TLEN_LO) total_length[7:0] = value;
		// Only the low six bits of the flags byte belong to the fragment test.
		if (pos == POS_FRAG_HI) fragment_field[13:8] = value[5:0];
		if (pos == POS_FRAG_LO) fragment_field[7:0] = value;
		if (pos == POS_PROTO) protocol_reg = value;
		if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) source_reg = {source_reg[23:0], value};
		if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) dest_reg = {dest_reg[23:0], value};
		if (pos >= ETH_HDR_LEN &&
		    (pos - ETH_HDR_LEN) < COUNT_W'({header_words, 2'b00})) begin
			if (!pos[0]) begin
				pending_high = value;
			end else begin
				acc = {1'b0, checksum_sum} + {1'b0, pending_high, value};
				checksum_sum = acc[15:0] + 16'(acc[16]);
			end
		end
		if (byte_count != COUNT_MAX) byte_count++;
		if (!is_last) return;

		flen = (pos != COUNT_MAX) ? pos + 1'b1 : COUNT_MAX;
		ihl_bytes = {header_words, 2'b00};
		if (flen < MIN_FRAME_LEN) st = ST_SHORT;
		else if (!ethertype_ok) st = ST_NOT_IPV4;
		else if (version_field != IP_VERSION) st = ST_VERSION;
		else if (ihl_bytes < MIN_IHL || total_length < 16'(ihl_bytes) ||
		         COUNT_W'(total_length) + ETH_HDR_LEN > flen) st = ST_LENGTH;
		else if (checksum_sum != SUM_GOOD) st = ST_CHECKSUM;
		else if (fragment_field != '0) st = ST_FRAGMENT;
		else if (dest_reg != station_address) st = ST_DEST;
		else st = ST_OK;

		verdict = '0;
		verdict.status = st;
		if (st == ST_OK) begin
			verdict.protocol = protocol_reg;
			verdict.source = source_reg;
			verdict.offset = 7'(ETH_HDR_LEN + COUNT_W'(ihl_bytes));
			verdict.length = total_length - 16'(ihl_bytes);
		end
		expected_verdicts.push_back(verdict);
		clear_frame();
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endfunction

	function void check_result(logic [2:0] st, logic [7:0] proto, logic [31:0] src,
	                           logic [6:0] off, logic [15:0] len);
		result_t want;
		if (expected_verdicts.size() == 0) begin
			mismatches++;
			$display("%0t: status expected no verdict, got verdict with status %0d",
			         $time, st);
			return;
		end
		want = expected_verdicts.pop_front();
		verdicts_checked++;
		status_seen[want.status]++;
		compare_field("status", want.status, st);
		compare_field("protocol", want.protocol, proto);
		compare_field("source_address", want.source, src);
		compare_field("payload_offset", want.offset, off);
		compare_field("payload_length", want.length, len);
	endfunction
endclass

module testbench;
	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        empty;
	logic        pop;
	logic [2:0]  status;
	logic [7:0]  protocol;
	logic [31:0] source_address;
	logic [6:0]  payload_offset;
	logic [15:0] payload_length;
	logic        local_address_we;
	logic [31:0] local_address;

	bit          calm;
	bit          hold_request;
	int unsigned bytes_sent;
	logic [7:0]  frame_q[$];

	header_verdict_predictor verdicts = new();

	ipv4_receive_header_checker u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.empty            (empty),
		.pop              (pop),
		.status           (status),
		.protocol         (protocol),
		.source_address   (source_address),
		.payload_offset   (payload_offset),
		.payload_length   (payload_length),
		.local_address_we (local_address_we),
		.local_address    (local_address)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("ipv4_receive_header_checker: mismatch");
		$finish;
	end

	// Result side: random pop gaps, plus one long hold-off on request.
	initial begin
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				pop <= 1'b0;
				repeat (400) @(negedge clk);
				hold_request = 1'b0;
			end
			pop <= calm || ($urandom_range(99) >= 22);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			verdicts.check_result(status, protocol, source_address, payload_offset,
			                      payload_length);
	end

	task automatic send_byte(input logic [7:0] value, input logic is_last);
		while (!calm && $urandom_range(99) < 22) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		data_byte <= value;
		last_byte <= is_last;
		@(posedge clk);
		while (full) @(posedge clk);
		verdicts.note_byte(value, is_last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int unsigned k = 0; k < frame_q.size(); k++)
			send_byte(frame_q[k], k == frame_q.size() - 1);
	endtask

	// Builds a well-formed frame for the current station address, then breaks it
	// in the way the fault asks; the noise and zeros faults send random or zero bytes instead.
	task automatic build_frame(input frame_fault_t fault, input int unsigned ihl_words,
	                           input int unsigned payload_len);
		int unsigned hdr_len;
		int unsigned k;
		logic [15:0] tot;
		logic [16:0] acc;
		logic [15:0] word_sum;
		logic [7:0]  flags_hi;
		logic [3:0]  ver;
		logic [31:0] dest;
		frame_q.delete();
		if (fault == FAULT_NOISE) begin
			repeat ($urandom_range(80, 1)) frame_q.push_back(8'($urandom));
			return;
		end
		if (fault == FAULT_ZEROS) begin
			repeat (MIN_FRAME_LEN) frame_q.push_back(8'h00);
			return;
		end
		hdr_len = ihl_words * 4;
		tot = 16'(hdr_len + payload_len);
		flags_hi = {2'($urandom), 6'd0};
		dest = verdicts.station_address;
		if (fault == FAULT_DEST) dest = dest ^ 32'($urandom_range(32'hFFFF_FFFF, 1));

		repeat (12) frame_q.push_back(8'($urandom));
		frame_q.push_back(ETYPE_HI);
		frame_q.push_back(ETYPE_LO);
		frame_q.push_back({IP_VERSION, 4'(ihl_words)});
		frame_q.push_back(8'($urandom));
		frame_q.push_back(tot[15:8]);
		frame_q.push_back(tot[7:0]);
		repeat (2) frame_q.push_back(8'($urandom));
		frame_q.push_back(flags_hi);
		frame_q.push_back(8'h00);
		repeat (2) frame_q.push_back(8'($urandom));
		repeat (2) frame_q.push_back(8'h00);
		repeat (4) frame_q.push_back(8'($urandom));
		for (k = 0; k < 4; k++) frame_q.push_back(dest[31 - 8 * k -: 8]);
		repeat (hdr_len - 20) frame_q.push_back(8'($urandom));
		repeat (payload_len) frame_q.push_back(8'($urandom));
		repeat ($urandom_range(6)) frame_q.push_back(8'($urandom));

		case (fault)
			FAULT_VERSION: begin
				ver = 4'($urandom_range(14));
				if (ver >= IP_VERSION) ver++;
				frame_q[14] = {ver, 4'(ihl_words)};
			end
			FAULT_IHL: frame_q[14] = {IP_VERSION, 4'($urandom_range(4))};
			FAULT_TLEN_SMALL: begin
				tot = 16'($urandom_range(hdr_len - 1));
				frame_q[16] = tot[15:8];
				frame_q[17] = tot[7:0];
			end
			FAULT_TLEN_LONG: begin
				tot = 16'(frame_q.size() - 13 + $urandom_range(40));
				frame_q[16] = tot[15:8];
				frame_q[17] = tot[7:0];
			end
			FAULT_FRAGMENT: begin
				frame_q[20] = {flags_hi[7:6], 6'($urandom)};
				frame_q[21] = 8'($urandom);
				if (frame_q[20][5:0] == 6'd0 && frame_q[21] == 8'h00) frame_q[21] = 8'h01;
			end
			default: ;
		endcase

		word_sum = '0;
		for (k = 14; k < 14 + hdr_len; k += 2) begin
			acc = {1'b0, word_sum} + {1'b0, frame_q[k], frame_q[k + 1]};
			word_sum = acc[15:0] + 16'(acc[16]);
		end
		frame_q[24] = ~word_sum[15:8];
		frame_q[25] = ~word_sum[7:0];

		case (fault)
			FAULT_CHECKSUM: begin
				k = 22 + $urandom_range(11);
				frame_q[k] = frame_q[k] ^ 8'($urandom_range(255, 1));
			end
			FAULT_ETHERTYPE: begin
				k = 12 + $urandom_range(1);
				frame_q[k] = frame_q[k] ^ 8'($urandom_range(255, 1));
			end
			FAULT_SHORT: begin
				k = $urandom_range(MIN_FRAME_LEN - 1, 1);
				while (frame_q.size() > k) void'(frame_q.pop_back());
			end
			default: ;
		endcase
	endtask

	task automatic run_frame(input frame_fault_t fault, input int unsigned ihl_words,
	                         input int unsigned payload_len);
		build_frame(fault, ihl_words, payload_len);
		send_frame();
	endtask

	task automatic drain_verdicts();
		push <= 1'b0;
		while (verdicts.outstanding() != 0) @(negedge clk);
	endtask

	task automatic set_local(input logic [31:0] addr);
		drain_verdicts();
		repeat (4) @(negedge clk);
		local_address_we <= 1'b1;
		local_address <= addr;
		@(negedge clk);
		local_address_we <= 1'b0;
		verdicts.station_address = addr;
	endtask

	initial begin
		int unsigned  p;
		int unsigned  phase_start;
		int unsigned  phase_frames;
		int unsigned  ihl;
		logic [31:0]  addr_plan[6];
		frame_fault_t fault;

		push = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		local_address_we = 1'b0;
		local_address = '0;
		calm = 1'b0;
		hold_request = 1'b0;
		bytes_sent = 0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed frames: smallest and largest headers, each failure, short edges.
		set_local(32'hC0A8_0107);
		run_frame(FAULT_NONE, 5, 0);
		run_frame(FAULT_NONE, 15, 3);
		for (int f = FAULT_SHORT; f <= FAULT_ZEROS; f++)
			run_frame(frame_fault_t'(f), 5, 4);
		build_frame(FAULT_NONE, 5, 0);
		frame_q = frame_q[0:0];
		send_frame();
		build_frame(FAULT_NONE, 5, 0);
		frame_q = frame_q[0:32];
		send_frame();

		addr_plan[0] = 32'h0000_0000;
		addr_plan[1] = 32'hFFFF_FFFF;
		addr_plan[2] = $urandom;
		addr_plan[3] = $urandom;
		addr_plan[4] = 32'h0000_0001;
		addr_plan[5] = $urandom;
		for (p = 0; p < 6; p++) begin
			set_local(addr_plan[p]);
			calm = (p == 2);
			if (p == 3) begin
				// Short frames keep producing verdicts while the reader holds off.
				hold_request = 1'b1;
				repeat (12) run_frame(FAULT_SHORT, 5, 0);
			end
			phase_start = bytes_sent;
			phase_frames = 0;
			while (bytes_sent - phase_start < 130 || phase_frames < 2) begin
				fault = ($urandom_range(99) < 50) ? FAULT_NONE :
				        frame_fault_t'($urandom_range(FAULT_NOISE, FAULT_SHORT));
				ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
				run_frame(fault, ihl, $urandom_range(24));
				phase_frames++;
			end
		end

		calm = 1'b0;
		drain_verdicts();
		repeat (10) @(negedge clk);
		$display("Checked %0d verdicts over %0d bytes, seven station addresses.",
		         verdicts.verdicts_checked, bytes_sent);
		$display("Verdicts by status 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
		         verdicts.status_seen[0], verdicts.status_seen[1], verdicts.status_seen[2],
		         verdicts.status_seen[3], verdicts.status_seen[4], verdicts.status_seen[5],
		         verdicts.status_seen[6], verdicts.status_seen[7]);
		if (verdicts.mismatches == 0 && verdicts.outstanding() == 0)
			$display("ipv4_receive_header_checker: match");
		else
			$display("ipv4_receive_header_checker: mismatch");
		$finish;
	end
endmodule
